### design/smcm_pkg.sv
// ----------------------------------------------------------------------------
// smcm_pkg: shared types and constants of the servo move completion monitor
// Request and error codes, register map, reset values and payload structs.
// ----------------------------------------------------------------------------
package smcm_pkg;

    // request codes
    localparam logic [2:0] REQ_START    = 3'd0;
    localparam logic [2:0] REQ_FB_OK    = 3'd1;
    localparam logic [2:0] REQ_FB_FAIL  = 3'd2;
    localparam logic [2:0] REQ_EVALUATE = 3'd3;
    localparam logic [2:0] REQ_CANCEL   = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_FB_TIMEOUT  = 3'd1;
    localparam logic [2:0] ERR_MOVE_TIMEOUT = 3'd2;
    localparam logic [2:0] ERR_NO_MOTION   = 3'd3;
    localparam logic [2:0] ERR_STOP_SHORT  = 3'd4;
    localparam logic [2:0] ERR_STALLED     = 3'd5;

    // register map, word index
    localparam int          ADDR_W = 5;
    localparam logic [2:0] REG_START_GRACE   = 3'd0;
    localparam logic [2:0] REG_START_CONFIRM = 3'd1;
    localparam logic [2:0] REG_STOP_SETTLE   = 3'd2;
    localparam logic [2:0] REG_NO_PROGRESS   = 3'd3;
    localparam logic [2:0] REG_MOVE_TIMEOUT  = 3'd4;
    localparam logic [2:0] REG_FB_TIMEOUT    = 3'd5;
    localparam logic [2:0] REG_POS_TOL       = 3'd6;
    localparam logic [2:0] REG_SNAP_STEPS    = 3'd7;

    // register reset values
    localparam logic [15:0] RST_START_GRACE   = 16'd200;
    localparam logic [15:0] RST_START_CONFIRM = 16'd1500;
    localparam logic [15:0] RST_STOP_SETTLE   = 16'd500;
    localparam logic [15:0] RST_NO_PROGRESS   = 16'd4000;
    localparam logic [15:0] RST_MOVE_TIMEOUT  = 16'd15000;
    localparam logic [15:0] RST_FB_TIMEOUT    = 16'd2000;
    localparam logic [7:0]  RST_POS_TOL       = 8'd4;
    localparam logic [7:0]  RST_SNAP_STEPS    = 8'd32;

    localparam logic [3:0] FAIL_COUNT_MAX = 4'd15;

    typedef struct packed {
        logic [15:0] start_grace_ms;
        logic [15:0] start_confirm_ms;
        logic [15:0] stop_settle_ms;
        logic [15:0] no_progress_ms;
        logic [15:0] move_timeout_ms;
        logic [15:0] fb_limit_ms;
        logic [7:0]  position_tolerance;
        logic [7:0]  snap_steps;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [31:0]        now_ms;
        logic signed [15:0] start_delta;
        logic signed [15:0] speed_sample;
        logic               moving_bit;
        logic signed [15:0] remaining_sample;
    } req_t;

    typedef struct packed {
        logic       moving;
        logic       stop_request;
        logic [2:0] error_code;
        logic       blocked;
        logic       feedback_healthy;
    } rsp_t;

    // magnitude of a 16-bit signed value; -32768 maps to 32768
    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        logic [15:0] r;
        r = v[15] ? 16'(-v) : 16'(v);
        return r;
    endfunction

endpackage

### design/smcm_if.sv
// ----------------------------------------------------------------------------
// smcm_if: valid/ready channels of the servo move completion monitor
// One interface for request words, one for result words.
// ----------------------------------------------------------------------------
interface smcm_req_if;
    logic           valid;
    logic           ready;
    smcm_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface smcm_rsp_if;
    logic           valid;
    logic           ready;
    smcm_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### design/smcm_regs.sv
// ----------------------------------------------------------------------------
// smcm_regs: configuration register file
// APB-style write and read of the eight timing and tolerance registers.
// ----------------------------------------------------------------------------
module smcm_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smcm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output smcm_pkg::cfg_t              cfg
);

    smcm_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_grace_ms      <= smcm_pkg::RST_START_GRACE;
            cfg_reg.start_confirm_ms    <= smcm_pkg::RST_START_CONFIRM;
            cfg_reg.stop_settle_ms      <= smcm_pkg::RST_STOP_SETTLE;
            cfg_reg.no_progress_ms      <= smcm_pkg::RST_NO_PROGRESS;
            cfg_reg.move_timeout_ms     <= smcm_pkg::RST_MOVE_TIMEOUT;
            cfg_reg.fb_limit_ms         <= smcm_pkg::RST_FB_TIMEOUT;
            cfg_reg.position_tolerance  <= smcm_pkg::RST_POS_TOL;
            cfg_reg.snap_steps          <= smcm_pkg::RST_SNAP_STEPS;
        end
        else if (wr_en)
        begin
            case (idx)
                smcm_pkg::REG_START_GRACE:   cfg_reg.start_grace_ms      <= pwdata[15:0];
                smcm_pkg::REG_START_CONFIRM: cfg_reg.start_confirm_ms    <= pwdata[15:0];
                smcm_pkg::REG_STOP_SETTLE:   cfg_reg.stop_settle_ms      <= pwdata[15:0];
                smcm_pkg::REG_NO_PROGRESS:   cfg_reg.no_progress_ms      <= pwdata[15:0];
                smcm_pkg::REG_MOVE_TIMEOUT:  cfg_reg.move_timeout_ms     <= pwdata[15:0];
                smcm_pkg::REG_FB_TIMEOUT:    cfg_reg.fb_limit_ms         <= pwdata[15:0];
                smcm_pkg::REG_POS_TOL:       cfg_reg.position_tolerance  <= pwdata[7:0];
                smcm_pkg::REG_SNAP_STEPS:    cfg_reg.snap_steps          <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            smcm_pkg::REG_START_GRACE:   prdata = {16'd0, cfg_reg.start_grace_ms};
            smcm_pkg::REG_START_CONFIRM: prdata = {16'd0, cfg_reg.start_confirm_ms};
            smcm_pkg::REG_STOP_SETTLE:   prdata = {16'd0, cfg_reg.stop_settle_ms};
            smcm_pkg::REG_NO_PROGRESS:   prdata = {16'd0, cfg_reg.no_progress_ms};
            smcm_pkg::REG_MOVE_TIMEOUT:  prdata = {16'd0, cfg_reg.move_timeout_ms};
            smcm_pkg::REG_FB_TIMEOUT:    prdata = {16'd0, cfg_reg.fb_limit_ms};
            smcm_pkg::REG_POS_TOL:       prdata = {24'd0, cfg_reg.position_tolerance};
            smcm_pkg::REG_SNAP_STEPS:    prdata = {24'd0, cfg_reg.snap_steps};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

### design/smcm_core.sv
// ----------------------------------------------------------------------------
// smcm_core: move supervision state and pipeline
// Input register, single-pass state update, result register.
// ----------------------------------------------------------------------------
module smcm_core #(
    parameter int MAX_FAILS        = 10,
    parameter int SPEED_STOP_LIMIT = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  smcm_pkg::cfg_t cfg,
    smcm_req_if.sink       req,
    smcm_rsp_if.source     rsp
);

    // pipeline registers
    logic           in_valid_reg;
    smcm_pkg::req_t in_data_reg;
    logic           out_valid_reg;
    smcm_pkg::rsp_t out_data_reg;
    logic           advance;
    logic           fire;

    // supervision state
    logic        active_reg, active_next;
    logic        observed_reg, observed_next;
    logic [31:0] start_time_reg, start_time_next;
    logic [31:0] last_good_reg, last_good_next;
    logic        ever_good_reg, ever_good_next;
    logic        settle_valid_reg, settle_valid_next;
    logic [31:0] settle_since_reg, settle_since_next;
    logic [31:0] progress_time_reg, progress_time_next;
    logic        best_none_reg, best_none_next;
    logic [15:0] best_rem_reg, best_rem_next;
    logic signed [15:0] speed_held_reg, speed_held_next;
    logic        moving_held_reg, moving_held_next;
    logic signed [15:0] rem_held_reg, rem_held_next;
    logic [3:0]  fail_count_reg, fail_count_next;
    logic        blocked_reg, blocked_next;
    logic [2:0]  error_reg, error_next;

    smcm_pkg::rsp_t rsp_next;
    logic        stop;

    // evaluation terms
    logic [31:0] now;
    logic [31:0] elapsed;
    logic [31:0] fb_age;
    logic [31:0] fb_age_out;
    logic [15:0] rem;
    logic [15:0] spd;
    logic [16:0] tol17;
    logic        spd_stop;
    logic        obs;
    logic        prog_upd;
    logic        settled;
    logic [31:0] prog_after;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || advance;
    assign fire      = in_valid_reg && advance;

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

    assign now      = in_data_reg.now_ms;
    assign elapsed  = now - start_time_reg;
    assign fb_age   = now - last_good_reg;
    assign rem      = smcm_pkg::mag16(rem_held_reg);
    assign spd      = smcm_pkg::mag16(speed_held_reg);
    assign tol17    = {9'd0, cfg.position_tolerance};
    assign spd_stop = spd <= 16'(SPEED_STOP_LIMIT);

    always_comb
    begin
        active_next        = active_reg;
        observed_next      = observed_reg;
        start_time_next    = start_time_reg;
        last_good_next     = last_good_reg;
        ever_good_next     = ever_good_reg;
        settle_valid_next  = settle_valid_reg;
        settle_since_next  = settle_since_reg;
        progress_time_next = progress_time_reg;
        best_none_next     = best_none_reg;
        best_rem_next      = best_rem_reg;
        speed_held_next    = speed_held_reg;
        moving_held_next   = moving_held_reg;
        rem_held_next      = rem_held_reg;
        fail_count_next    = fail_count_reg;
        blocked_next       = blocked_reg;
        error_next         = error_reg;
        stop               = 1'b0;
        obs                = 1'b0;
        prog_upd           = 1'b0;
        settled            = 1'b0;
        prog_after         = progress_time_reg;

        case (in_data_reg.req_type)
            smcm_pkg::REQ_START:
            begin
                error_next        = smcm_pkg::ERR_NONE;
                settle_valid_next = 1'b0;
                observed_next     = 1'b0;
                if (smcm_pkg::mag16(in_data_reg.start_delta) <= {8'd0, cfg.position_tolerance})
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    start_time_next    = now;
                    progress_time_next = now;
                    best_none_next     = 1'b1;
                    active_next        = 1'b1;
                end
            end
            smcm_pkg::REQ_FB_OK:
            begin
                speed_held_next  = in_data_reg.speed_sample;
                moving_held_next = in_data_reg.moving_bit;
                rem_held_next    = in_data_reg.remaining_sample;
                fail_count_next  = 4'd0;
                blocked_next     = 1'b0;
                last_good_next   = now;
                ever_good_next   = 1'b1;
            end
            smcm_pkg::REQ_FB_FAIL:
            begin
                if (fail_count_reg < smcm_pkg::FAIL_COUNT_MAX)
                    fail_count_next = fail_count_reg + 4'd1;
                if (fail_count_next >= 4'(MAX_FAILS))
                    blocked_next = 1'b1;
            end
            smcm_pkg::REQ_EVALUATE:
            begin
                if (active_reg && elapsed >= {16'd0, cfg.start_grace_ms})
                begin
                    if (fb_age > {16'd0, cfg.fb_limit_ms})
                    begin
                        stop             = 1'b1;
                        error_next       = smcm_pkg::ERR_FB_TIMEOUT;
                        speed_held_next  = 16'sd0;
                        moving_held_next = 1'b0;
                    end
                    else if (elapsed > {16'd0, cfg.move_timeout_ms})
                    begin
                        stop       = 1'b1;
                        error_next = smcm_pkg::ERR_MOVE_TIMEOUT;
                    end
                    else
                    begin
                        obs           = observed_reg || !spd_stop || moving_held_reg;
                        observed_next = obs;
                        if (!obs)
                        begin
                            if (elapsed >= {16'd0, cfg.start_confirm_ms})
                            begin
                                stop       = 1'b1;
                                error_next = smcm_pkg::ERR_NO_MOTION;
                            end
                        end
                        else
                        begin
                            // track the closest distance seen, with tolerance as hysteresis
                            prog_upd = ({1'b0, rem} > tol17) && (best_none_reg ||
                                       ({1'b0, rem} + tol17 < {1'b0, best_rem_reg}));
                            if (prog_upd)
                            begin
                                best_rem_next      = rem;
                                best_none_next     = 1'b0;
                                progress_time_next = now;
                                prog_after         = now;
                            end
                            if ((spd_stop && !moving_held_reg) || ({1'b0, rem} <= tol17) ||
                                (spd_stop && rem <= {8'd0, cfg.snap_steps}))
                            begin
                                if (!settle_valid_reg)
                                begin
                                    settle_valid_next = 1'b1;
                                    settle_since_next = now;
                                end
                                else if (now - settle_since_reg >= {16'd0, cfg.stop_settle_ms})
                                begin
                                    settled = 1'b1;
                                    if (rem > {8'd0, cfg.snap_steps})
                                        error_next = smcm_pkg::ERR_STOP_SHORT;
                                    active_next       = 1'b0;
                                    observed_next     = 1'b0;
                                    settle_valid_next = 1'b0;
                                end
                            end
                            else
                            begin
                                settle_valid_next = 1'b0;
                            end
                            if (!settled && ({1'b0, rem} > tol17) && !best_none_next &&
                                (now - prog_after >= {16'd0, cfg.no_progress_ms}))
                            begin
                                stop       = 1'b1;
                                error_next = smcm_pkg::ERR_STALLED;
                            end
                        end
                    end
                end
            end
            smcm_pkg::REQ_CANCEL:
            begin
                stop       = 1'b1;
                error_next = smcm_pkg::ERR_NONE;
            end
            default: ;
        endcase

        // common stop actions; the error code was set by the calling check
        if (stop)
        begin
            rem_held_next     = 16'sd0;
            active_next       = 1'b0;
            observed_next     = 1'b0;
            settle_valid_next = 1'b0;
        end
    end

    assign fb_age_out = now - last_good_next;

    always_comb
    begin
        rsp_next.moving           = active_next;
        rsp_next.stop_request     = stop;
        rsp_next.error_code       = error_next;
        rsp_next.blocked          = blocked_next;
        rsp_next.feedback_healthy = ever_good_next && !blocked_next &&
                                    (fb_age_out <= {16'd0, cfg.fb_limit_ms});
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload words
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
            in_data_reg <= req.payload;
        if (fire)
            out_data_reg <= rsp_next;
    end

    // state advances once per word as it moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= 1'b0;
            observed_reg      <= 1'b0;
            start_time_reg    <= 32'd0;
            last_good_reg     <= 32'd0;
            ever_good_reg     <= 1'b0;
            settle_valid_reg  <= 1'b0;
            settle_since_reg  <= 32'd0;
            progress_time_reg <= 32'd0;
            best_none_reg     <= 1'b1;
            best_rem_reg      <= 16'd0;
            speed_held_reg    <= 16'sd0;
            moving_held_reg   <= 1'b0;
            rem_held_reg      <= 16'sd0;
            fail_count_reg    <= 4'd0;
            blocked_reg       <= 1'b0;
            error_reg         <= smcm_pkg::ERR_NONE;
        end
        else if (fire)
        begin
            active_reg        <= active_next;
            observed_reg      <= observed_next;
            start_time_reg    <= start_time_next;
            last_good_reg     <= last_good_next;
            ever_good_reg     <= ever_good_next;
            settle_valid_reg  <= settle_valid_next;
            settle_since_reg  <= settle_since_next;
            progress_time_reg <= progress_time_next;
            best_none_reg     <= best_none_next;
            best_rem_reg      <= best_rem_next;
            speed_held_reg    <= speed_held_next;
            moving_held_reg   <= moving_held_next;
            rem_held_reg      <= rem_held_next;
            fail_count_reg    <= fail_count_next;
            blocked_reg       <= blocked_next;
            error_reg         <= error_next;
        end
    end

    // a stopped move is never reported as still running
    a_stop_ends_move: assert property (@(posedge clk) disable iff (!rst_n)
        fire && stop |=> !active_reg && !out_data_reg.moving)
        else $error("stop request left the move active");

    // blocked only after enough consecutive failures
    a_blocked_count: assert property (@(posedge clk) disable iff (!rst_n)
        blocked_reg |-> fail_count_reg >= 4'(MAX_FAILS))
        else $error("blocked flag without enough failed reads");

    // settle timer and motion flag only live within a move
    a_settle_in_move: assert property (@(posedge clk) disable iff (!rst_n)
        (settle_valid_reg || observed_reg) |-> active_reg)
        else $error("settle or observed state outside a move");

    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> in_valid_reg && out_valid_reg && !rsp.ready)
        else $error("input stalled without a waiting result");

endmodule

### design/servo_move_completion_monitor.sv
// ----------------------------------------------------------------------------
// servo_move_completion_monitor: supervision of a single servo move
// Register file plus state-update pipeline with valid/ready channels.
// ----------------------------------------------------------------------------
// The monitor takes one request word per clock cycle and returns one result
// word for each: the word sits in an input register, passes once through the
// move-supervision compare logic that updates the state, and lands in a result
// register. Back-to-back words see each other's state updates without a
// bubble; the input side stalls only while a result waits on the output.
// Registers are written over the APB port at byte address 4*i and must be
// changed only while no word is in flight.
module servo_move_completion_monitor #(
    parameter int MAX_FAILS        = 10,
    parameter int SPEED_STOP_LIMIT = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    smcm_req_if.sink                    req,
    smcm_rsp_if.source                  rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smcm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    smcm_pkg::cfg_t cfg;

    smcm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    smcm_core #(
        .MAX_FAILS        (MAX_FAILS),
        .SPEED_STOP_LIMIT (SPEED_STOP_LIMIT)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
